// File: hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the circular deque modules.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int OPCODE_W    = 3;
  localparam int CAP_W       = 5;
  localparam int MODE_W      = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = CAP_W;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH_REAR  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_PEEK_REAR  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_STATUS     = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOWED = 2'd3;

  // restriction modes
  localparam logic [MODE_W-1:0] MODE_INPUT_RESTRICTED  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OUTPUT_RESTRICTED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNRESTRICTED      = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY         = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESTRICTION_MODE = 1'd1;

  localparam logic [CAP_W-1:0]   CAPACITY_RESET = 5'd16;
  localparam logic [VALUE_W-1:0] EMPTY_READ     = '1;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic                      is_empty;
    logic                      is_full;
  } out_item_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
  } ctrl_cmd_t;

endpackage

// File: hdl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: takes a transaction, runs the execute state, holds the result.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output dq_pkg::ctrl_cmd_t cmd
);

  dq_pkg::state_t state;
  dq_pkg::state_t state_next;
  logic           room;

  // output register free by the time the execute cycle loads it
  assign room = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      dq_pkg::S_IDLE: begin
        if (in_valid && room) state_next = dq_pkg::S_EXEC;
      end
      dq_pkg::S_EXEC: begin
        state_next = dq_pkg::S_IDLE;
      end
      default: begin
        state_next = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      dq_pkg::S_IDLE: begin
        in_stall   = !room;
        cmd.accept = in_valid && room;
      end
      dq_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Element store, front/rear pointers, configuration and result register.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dq_pkg::ctrl_cmd_t             cmd,
  input  dq_pkg::in_item_t              in_data,
  input  logic                          cfg_write,
  input  logic [dq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dq_pkg::CFG_DATA_W-1:0] cfg_data,
  output dq_pkg::out_item_t             out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int EXT_W = (IDX_W + 1 > dq_pkg::CAP_W) ? IDX_W + 1 : dq_pkg::CAP_W;
  localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(DEPTH);
  localparam int RESET_EFF =
    (int'(dq_pkg::CAPACITY_RESET) > DEPTH) ? DEPTH : int'(dq_pkg::CAPACITY_RESET);
  localparam logic [IDX_W-1:0] LAST_RESET = IDX_W'(RESET_EFF - 1);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i,
                                                input logic [IDX_W-1:0] last);
    return (i == last) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i,
                                                input logic [IDX_W-1:0] last);
    return (i == '0) ? last : i - IDX_W'(1);
  endfunction

  logic [dq_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [dq_pkg::VALUE_W-1:0] rdata;
  logic [IDX_W-1:0]           raddr;

  logic [IDX_W-1:0]          last;       // effective capacity minus one
  logic [dq_pkg::MODE_W-1:0] mode;
  logic [IDX_W-1:0]          front;
  logic [IDX_W-1:0]          rear;
  logic                      empty;
  dq_pkg::in_item_t          item;

  logic [IDX_W-1:0]           front_next;
  logic [IDX_W-1:0]           rear_next;
  logic                       empty_next;
  logic                       full_now;
  logic                       we;
  logic [IDX_W-1:0]           waddr;
  dq_pkg::out_item_t          result;

  logic [EXT_W-1:0] cap_ext;
  logic [IDX_W-1:0] last_wr;

  // clamp written capacity to 1..DEPTH
  always_comb begin
    cap_ext = EXT_W'(cfg_data[dq_pkg::CAP_W-1:0]);
    if (cap_ext == '0) begin
      last_wr = '0;
    end else if (cap_ext > DEPTH_EXT) begin
      last_wr = IDX_W'(DEPTH - 1);
    end else begin
      last_wr = IDX_W'(cap_ext - EXT_W'(1));
    end
  end

  // read address picked from the incoming opcode
  always_comb begin
    case (in_data.opcode)
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: raddr = front;
      default:                                     raddr = rear;
    endcase
  end

  assign full_now = !empty && (wrap_inc(rear, last) == front);

  always_comb begin
    front_next        = front;
    rear_next         = rear;
    empty_next        = empty;
    we                = 1'b0;
    waddr             = front;
    result.read_value = '0;
    result.status     = dq_pkg::ST_OK;
    if ((item.opcode == dq_pkg::OP_PUSH_FRONT && mode == dq_pkg::MODE_INPUT_RESTRICTED) ||
        (item.opcode == dq_pkg::OP_POP_REAR && mode == dq_pkg::MODE_OUTPUT_RESTRICTED)) begin
      result.status = dq_pkg::ST_NOT_ALLOWED;
    end else begin
      case (item.opcode)
        dq_pkg::OP_PUSH_REAR, dq_pkg::OP_PUSH_FRONT: begin
          if (full_now) begin
            result.status = dq_pkg::ST_FULL;
          end else if (empty) begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b0;
            we         = 1'b1;
            waddr      = '0;
          end else if (item.opcode == dq_pkg::OP_PUSH_REAR) begin
            rear_next = wrap_inc(rear, last);
            we        = 1'b1;
            waddr     = rear_next;
          end else begin
            front_next = wrap_dec(front, last);
            we         = 1'b1;
            waddr      = front_next;
          end
        end
        dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_REAR,
        dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_REAR: begin
          if (empty) begin
            result.status     = dq_pkg::ST_EMPTY;
            result.read_value = dq_pkg::EMPTY_READ;
          end else begin
            result.read_value = rdata;
            if (item.opcode == dq_pkg::OP_POP_FRONT || item.opcode == dq_pkg::OP_POP_REAR) begin
              if (front == rear) begin
                front_next = '0;
                rear_next  = '0;
                empty_next = 1'b1;
              end else if (item.opcode == dq_pkg::OP_POP_FRONT) begin
                front_next = wrap_inc(front, last);
              end else begin
                rear_next = wrap_dec(rear, last);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    result.is_empty = empty_next;
    result.is_full  = !empty_next && (wrap_inc(rear_next, last) == front_next);
  end

  // element store
  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= item.push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
    end
    if (cmd.exec) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
      last  <= LAST_RESET;
      mode  <= dq_pkg::MODE_UNRESTRICTED;
    end else begin
      if (cmd.exec) begin
        front <= front_next;
        rear  <= rear_next;
        empty <= empty_next;
      end
      if (cfg_write) begin
        case (cfg_index)
          dq_pkg::CFG_CAPACITY: begin
            last  <= last_wr;
            front <= '0;
            rear  <= '0;
            empty <= 1'b1;
          end
          dq_pkg::CFG_RESTRICTION_MODE: begin
            mode <= cfg_data[dq_pkg::MODE_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: hdl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a circular element store with restriction modes.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   -------------------------------------
//   in        in_valid / in_stall     in_data  : opcode, push_value
//   out       out_valid / out_stall   out_data : read_value, status,
//                                                is_empty, is_full
//   cfg       cfg_write               cfg_index, cfg_data (no read-back)
//
// Each transaction passes through accept (store read issued from the
// current front or rear pointer) then execute (pointer update, store write,
// result register load). A new transaction is not taken while one is in
// execute; the registered read of the element store sets this pace.
// Reset (rst, synchronous): deque empty, pointers zero, capacity 16 (clamped
// to DEPTH), unrestricted mode. Store contents are not cleared.
// A stalled result sits in the output register; a new transaction is taken
// only once that register will be free for its execute cycle.
// ----------------------------------------------------------------------------
module circular_deque #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dq_pkg::in_item_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dq_pkg::out_item_t              out_data,
  input  logic                           cfg_write,
  input  logic [dq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dq_pkg::ctrl_cmd_t cmd;

  // sequencer: accept / execute / result hand-off
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // store, pointers, configuration and result register
  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// File: bench/circular_deque_tb.sv
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking bench for the circular deque. A short table of directed
// operations and register writes is followed by about 900 random operations
// in three idling regimes. Every reply is checked field by field against a
// typed-in reply or a cycle-free model of the deque kept inside the bench.
// ----------------------------------------------------------------------------
module circular_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH           = 16;
  localparam int SETTLE_CYCLES   = 4;     // result path runs through the accept and execute registers
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any transaction
  localparam int MAX_REPORTS     = 40;
  localparam int SEGMENTS        = 6;     // register settings per phase
  localparam int SEGMENT_OPS     = 50;

  // opcode 7 has no name in the package; the deque treats it as a status query
  localparam logic [dq_pkg::OPCODE_W-1:0] OP_SPARE = 3'd7;

  typedef enum bit {
    ROW_OP,
    ROW_CFG
  } row_kind_t;

  // one line of the directed table
  typedef struct {
    row_kind_t                        kind;
    dq_pkg::in_item_t                 item;
    bit                               typed;     // reply written out by hand below
    dq_pkg::out_item_t                want;
    logic [dq_pkg::CFG_INDEX_W-1:0]   reg_index;
    logic [dq_pkg::CFG_DATA_W-1:0]    reg_value;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  dq_pkg::in_item_t  in_data;
  logic              out_valid;
  logic              out_stall;
  dq_pkg::out_item_t out_data;
  logic              cfg_write;
  logic [dq_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [dq_pkg::CFG_DATA_W-1:0]  cfg_data;

  // hand-written reply travelling with the current input transaction
  logic              typed_reply_on;
  dq_pkg::out_item_t typed_reply;

  // idling rates in percent, changed per phase
  int                in_idle_pct;
  int                out_stall_pct;

  // deque model state
  logic [dq_pkg::VALUE_W-1:0] store_m [DEPTH];
  int unsigned                front_m;
  int unsigned                rear_m;
  bit                         empty_m;
  logic [dq_pkg::CAP_W-1:0]   cap_m;
  logic [dq_pkg::MODE_W-1:0]  mode_m;

  dq_pkg::out_item_t  deque_replies_q [$];

  int                 fail_count;
  int                 ops_sent;
  int                 replies_seen;
  int                 cfg_writes;
  int                 full_seen;
  int                 empty_seen;
  int                 refused_seen;

  circular_deque #(
    .DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Deque model
  // --------------------------------------------------------------------------

  // entries actually in use: 0 behaves as 1, anything above DEPTH as DEPTH
  function automatic int unsigned live_entries();
    if (cap_m == 0) return 1;
    if (32'(cap_m) > DEPTH) return DEPTH;
    return 32'(cap_m);
  endfunction

  function automatic int unsigned step_up(int unsigned i);
    return (i + 1 >= live_entries()) ? 0 : i + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned i);
    return (i == 0) ? live_entries() - 1 : i - 1;
  endfunction

  function automatic bit holds_full();
    return !empty_m && step_up(rear_m) == front_m;
  endfunction

  // performs one operation on the model and returns the reply it gives
  function automatic dq_pkg::out_item_t apply_deque_op(dq_pkg::in_item_t it);
    dq_pkg::out_item_t           r;
    logic [dq_pkg::OPCODE_W-1:0] op;
    op       = it.opcode;
    r        = '0;
    r.status = dq_pkg::ST_OK;
    // restriction check wins over the full and empty checks
    if ((op == dq_pkg::OP_PUSH_FRONT && mode_m == dq_pkg::MODE_INPUT_RESTRICTED) ||
        (op == dq_pkg::OP_POP_REAR && mode_m == dq_pkg::MODE_OUTPUT_RESTRICTED)) begin
      r.status = dq_pkg::ST_NOT_ALLOWED;
    end else if (op == dq_pkg::OP_PUSH_REAR || op == dq_pkg::OP_PUSH_FRONT) begin
      if (holds_full()) begin
        r.status = dq_pkg::ST_FULL;
      end else if (empty_m) begin
        // first element always lands in slot zero
        front_m    = 0;
        rear_m     = 0;
        empty_m    = 1'b0;
        store_m[0] = it.push_value;
      end else if (op == dq_pkg::OP_PUSH_REAR) begin
        rear_m          = step_up(rear_m);
        store_m[rear_m] = it.push_value;
      end else begin
        front_m          = step_down(front_m);
        store_m[front_m] = it.push_value;
      end
    end else if (op == dq_pkg::OP_POP_FRONT || op == dq_pkg::OP_POP_REAR ||
                 op == dq_pkg::OP_PEEK_FRONT || op == dq_pkg::OP_PEEK_REAR) begin
      if (empty_m) begin
        r.status     = dq_pkg::ST_EMPTY;
        r.read_value = dq_pkg::EMPTY_READ;
      end else begin
        r.read_value = (op == dq_pkg::OP_POP_FRONT || op == dq_pkg::OP_PEEK_FRONT) ?
                       store_m[front_m] : store_m[rear_m];
        if (op == dq_pkg::OP_POP_FRONT || op == dq_pkg::OP_POP_REAR) begin
          if (front_m == rear_m) begin
            front_m = 0;
            rear_m  = 0;
            empty_m = 1'b1;
          end else if (op == dq_pkg::OP_POP_FRONT) begin
            front_m = step_up(front_m);
          end else begin
            rear_m = step_down(rear_m);
          end
        end
      end
    end
    r.is_empty = empty_m;
    r.is_full  = holds_full();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sampled on the rising edge, inputs having settled since the
  // falling edge. Replies are checked before the transaction taken at the
  // same edge is modelled, as that one's reply cannot be out yet.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [dq_pkg::VALUE_W-1:0] want,
                             input logic [dq_pkg::VALUE_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0d ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    dq_pkg::out_item_t want;
    dq_pkg::out_item_t modelled;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (deque_replies_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0d ns: reply with nothing outstanding, expected none, got %h",
                     $time, out_data);
        end else begin
          want = deque_replies_q.pop_front();
          replies_seen++;
          check_field("read_value", want.read_value, out_data.read_value);
          check_field("status",     32'(want.status),   32'(out_data.status));
          check_field("is_empty",   32'(want.is_empty), 32'(out_data.is_empty));
          check_field("is_full",    32'(want.is_full),  32'(out_data.is_full));
          case (want.status)
            dq_pkg::ST_FULL:        full_seen++;
            dq_pkg::ST_EMPTY:       empty_seen++;
            dq_pkg::ST_NOT_ALLOWED: refused_seen++;
            default:                ;
          endcase
        end
      end

      // register writes land only while the deque is idle
      if (cfg_write) begin
        case (cfg_index)
          dq_pkg::CFG_CAPACITY: begin
            cap_m   = cfg_data;
            front_m = 0;
            rear_m  = 0;
            empty_m = 1'b1;
          end
          dq_pkg::CFG_RESTRICTION_MODE: mode_m = cfg_data[dq_pkg::MODE_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        modelled = apply_deque_op(in_data);
        ops_sent++;
        // the model advances either way; a typed row overrides its reply
        deque_replies_q.push_back(typed_reply_on ? typed_reply : modelled);
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks. Each is entered just after a falling edge and returns
  // just after one, so that every input changes on a falling edge.
  // --------------------------------------------------------------------------

  // offers one transaction and holds it until the deque takes it
  task automatic send_op(input dq_pkg::in_item_t it, input bit typed,
                         input dq_pkg::out_item_t want);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_data        <= it;
    typed_reply_on <= typed;
    typed_reply    <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // wait until every reply is back and the pipe has drained
  task automatic settle_deque();
    in_valid <= 1'b0;
    while (deque_replies_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [dq_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [dq_pkg::CFG_DATA_W-1:0] val);
    settle_deque();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_writes++;
  endtask

  function automatic plan_row_t op_row(input logic [dq_pkg::OPCODE_W-1:0] op,
                                       input logic [dq_pkg::VALUE_W-1:0] v,
                                       input bit typed = 1'b0,
                                       input dq_pkg::out_item_t want = '0);
    plan_row_t row;
    row.kind            = ROW_OP;
    row.item.opcode     = op;
    row.item.push_value = v;
    row.typed           = typed;
    row.want            = want;
    row.reg_index       = '0;
    row.reg_value       = '0;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [dq_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [dq_pkg::CFG_DATA_W-1:0] val);
    plan_row_t row;
    row           = op_row(dq_pkg::OP_STATUS, '0);
    row.kind      = ROW_CFG;
    row.reg_index = idx;
    row.reg_value = val;
    return row;
  endfunction

  // random operation; a filling trend leans on pushes, a draining one on pops
  function automatic dq_pkg::in_item_t random_op(input bit filling);
    dq_pkg::in_item_t it;
    int unsigned      r;
    r = $urandom_range(99);
    if (r < (filling ? 65 : 20))
      it.opcode = $urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_REAR;
    else if (r < (filling ? 75 : 70))
      it.opcode = $urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_REAR;
    else if (r < 90)
      it.opcode = $urandom_range(1) ? dq_pkg::OP_PEEK_FRONT : dq_pkg::OP_PEEK_REAR;
    else
      it.opcode = ($urandom_range(3) == 0) ? OP_SPARE : dq_pkg::OP_STATUS;
    case ($urandom_range(7))
      0:       it.push_value = 32'h7FFF_FFFF;
      1:       it.push_value = 32'h8000_0000;
      2:       it.push_value = '1;
      3:       it.push_value = '0;
      default: it.push_value = $urandom;
    endcase
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    plan_row_t                 plan [$];
    bit                        filling;
    logic [dq_pkg::CAP_W-1:0]  cap_pick;
    logic [dq_pkg::MODE_W-1:0] mode_pick;

    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    typed_reply_on = 1'b0;
    typed_reply    = '0;
    in_idle_pct    = 35;
    out_stall_pct  = 64;
    fail_count     = 0;
    ops_sent       = 0;
    replies_seen   = 0;
    cfg_writes     = 0;
    full_seen      = 0;
    empty_seen     = 0;
    refused_seen   = 0;

    // model starts as the deque leaves reset
    front_m = 0;
    rear_m  = 0;
    empty_m = 1'b1;
    cap_m   = dq_pkg::CAPACITY_RESET;
    mode_m  = dq_pkg::MODE_UNRESTRICTED;

    // Directed table. Replies are typed in where they are obvious; the rest
    // come from the model.
    // fresh out of reset: empty, and empty reads give all ones
    plan.push_back(op_row(dq_pkg::OP_STATUS, '0, 1'b1,
                          '{'0, dq_pkg::ST_OK, 1'b1, 1'b0}));
    plan.push_back(op_row(dq_pkg::OP_PEEK_FRONT, '0, 1'b1,
                          '{dq_pkg::EMPTY_READ, dq_pkg::ST_EMPTY, 1'b1, 1'b0}));
    plan.push_back(op_row(dq_pkg::OP_POP_REAR, '0, 1'b1,
                          '{dq_pkg::EMPTY_READ, dq_pkg::ST_EMPTY, 1'b1, 1'b0}));
    plan.push_back(op_row(OP_SPARE, '1, 1'b1,
                          '{'0, dq_pkg::ST_OK, 1'b1, 1'b0}));
    // extreme values in from both ends and back out again
    plan.push_back(op_row(dq_pkg::OP_PUSH_REAR, 32'h7FFF_FFFF, 1'b1,
                          '{'0, dq_pkg::ST_OK, 1'b0, 1'b0}));
    plan.push_back(op_row(dq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b1,
                          '{'0, dq_pkg::ST_OK, 1'b0, 1'b0}));
    plan.push_back(op_row(dq_pkg::OP_PEEK_FRONT, '0, 1'b1,
                          '{32'h8000_0000, dq_pkg::ST_OK, 1'b0, 1'b0}));
    plan.push_back(op_row(dq_pkg::OP_PEEK_REAR, '0, 1'b1,
                          '{32'h7FFF_FFFF, dq_pkg::ST_OK, 1'b0, 1'b0}));
    plan.push_back(op_row(dq_pkg::OP_POP_REAR, '0, 1'b1,
                          '{32'h7FFF_FFFF, dq_pkg::ST_OK, 1'b0, 1'b0}));
    plan.push_back(op_row(dq_pkg::OP_POP_FRONT, '0, 1'b1,
                          '{32'h8000_0000, dq_pkg::ST_OK, 1'b1, 1'b0}));
    // single-entry deque: one push fills it, a stored -1 pops with status ok
    plan.push_back(cfg_row(dq_pkg::CFG_CAPACITY, 5'd1));
    plan.push_back(op_row(dq_pkg::OP_PUSH_REAR, '1, 1'b1,
                          '{'0, dq_pkg::ST_OK, 1'b0, 1'b1}));
    plan.push_back(op_row(dq_pkg::OP_PUSH_FRONT, 32'd5, 1'b1,
                          '{'0, dq_pkg::ST_FULL, 1'b0, 1'b1}));
    plan.push_back(op_row(dq_pkg::OP_POP_FRONT, '0, 1'b1,
                          '{'1, dq_pkg::ST_OK, 1'b1, 1'b0}));
    // input restricted: push at front refused even when empty
    plan.push_back(cfg_row(dq_pkg::CFG_RESTRICTION_MODE,
                           {3'b000, dq_pkg::MODE_INPUT_RESTRICTED}));
    plan.push_back(op_row(dq_pkg::OP_PUSH_FRONT, 32'd1, 1'b1,
                          '{'0, dq_pkg::ST_NOT_ALLOWED, 1'b1, 1'b0}));
    plan.push_back(op_row(dq_pkg::OP_PUSH_REAR, '0, 1'b1,
                          '{'0, dq_pkg::ST_OK, 1'b0, 1'b1}));
    // output restricted: pop at rear refused, push at front now allowed
    plan.push_back(cfg_row(dq_pkg::CFG_RESTRICTION_MODE,
                           {3'b111, dq_pkg::MODE_OUTPUT_RESTRICTED}));
    plan.push_back(op_row(dq_pkg::OP_POP_REAR, '0, 1'b1,
                          '{'0, dq_pkg::ST_NOT_ALLOWED, 1'b0, 1'b1}));
    plan.push_back(op_row(dq_pkg::OP_PUSH_FRONT, 32'd3, 1'b1,
                          '{'0, dq_pkg::ST_FULL, 1'b0, 1'b1}));
    // capacity zero behaves as one, and the write empties the deque
    plan.push_back(cfg_row(dq_pkg::CFG_CAPACITY, 5'd0));
    plan.push_back(op_row(dq_pkg::OP_PUSH_REAR, 32'h5A5A_5A5A, 1'b1,
                          '{'0, dq_pkg::ST_OK, 1'b0, 1'b1}));
    plan.push_back(op_row(dq_pkg::OP_PEEK_REAR, '0, 1'b1,
                          '{32'h5A5A_5A5A, dq_pkg::ST_OK, 1'b0, 1'b1}));
    // capacity above depth clamps; mode 3 is unrestricted
    plan.push_back(cfg_row(dq_pkg::CFG_CAPACITY, 5'd31));
    plan.push_back(cfg_row(dq_pkg::CFG_RESTRICTION_MODE, 5'd3));
    plan.push_back(op_row(dq_pkg::OP_POP_REAR, '0, 1'b1,
                          '{dq_pkg::EMPTY_READ, dq_pkg::ST_EMPTY, 1'b1, 1'b0}));
    plan.push_back(op_row(dq_pkg::OP_PUSH_FRONT, 32'h1234_5678));
    plan.push_back(op_row(dq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5));
    plan.push_back(op_row(dq_pkg::OP_POP_REAR,   '0));
    // two entries: wrap of the front pointer fills it
    plan.push_back(cfg_row(dq_pkg::CFG_CAPACITY, 5'd2));
    plan.push_back(cfg_row(dq_pkg::CFG_RESTRICTION_MODE,
                           {3'b000, dq_pkg::MODE_UNRESTRICTED}));
    plan.push_back(op_row(dq_pkg::OP_PUSH_REAR, 32'd1, 1'b1,
                          '{'0, dq_pkg::ST_OK, 1'b0, 1'b0}));
    plan.push_back(op_row(dq_pkg::OP_PUSH_FRONT, 32'd2, 1'b1,
                          '{'0, dq_pkg::ST_OK, 1'b0, 1'b1}));
    plan.push_back(op_row(dq_pkg::OP_POP_FRONT, '0));
    plan.push_back(op_row(dq_pkg::OP_PEEK_REAR, '0));

    // synchronous reset, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_reg(plan[i].reg_index, plan[i].reg_value);
      else
        send_op(plan[i].item, plan[i].typed, plan[i].want);
    end

    // Random part: three idling regimes, each split into segments with a
    // fresh capacity and restriction mode. Small capacities dominate so the
    // full and wrap cases come up often.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin in_idle_pct = 35; out_stall_pct = 64; end
        1:       begin in_idle_pct = 64; out_stall_pct = 35; end
        default: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      endcase
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        case ($urandom_range(9))
          0:       cap_pick = 5'd0;
          1:       cap_pick = 5'd16;
          2:       cap_pick = 5'($urandom_range(31, 17));
          3, 4:    cap_pick = 5'($urandom_range(16, 1));
          default: cap_pick = 5'($urandom_range(5, 1));
        endcase
        mode_pick = 2'($urandom_range(3));
        write_reg(dq_pkg::CFG_CAPACITY, cap_pick);
        write_reg(dq_pkg::CFG_RESTRICTION_MODE, {3'($urandom_range(7)), mode_pick});
        filling = 1'b1;
        repeat (SEGMENT_OPS) begin
          if ($urandom_range(24) == 0) filling = !filling;
          send_op(random_op(filling), 1'b0, '0);
        end
      end
    end

    settle_deque();

    $display("Covered %0d operations and %0d register writes over three idling regimes.",
             ops_sent, cfg_writes);
    $display("Replies checked: %0d, of them %0d full, %0d empty, %0d refused.",
             replies_seen, full_seen, empty_seen, refused_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog: any transaction on either channel or the register port
  // resets the count of quiet cycles
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0d ns: no transaction for %0d cycles, run abandoned", $time, WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
